// File: rtl/core/mccd_pkg.sv
// mccd_pkg: shared widths, reset constants and lane result type for the
// multi-channel counter debouncer; no dependencies
`timescale 1ns / 1ps

package mccd_pkg;

  // width of the raw and debounced level words
  localparam int unsigned FIELD_W = 16;
  // width of each lane's integrating counter and of the threshold
  localparam int unsigned CNT_W   = 8;

  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [CNT_W-1:0]   count_t;

  localparam count_t THRESHOLD_RESET = count_t'(10);
  localparam count_t CNT_MAX         = '1;

  // what one lane reports for the current request
  typedef struct packed {
    logic level;
    logic press;
  } lane_out_t;

endpackage

// File: rtl/core/mccd_stream_if.sv
// valid/ready stream interfaces for raw samples and debounced results
// depends on mccd_pkg for the field type
`timescale 1ns / 1ps

interface mccd_in_if;
  logic              valid;
  logic              ready;
  mccd_pkg::field_t  raw_levels;

  modport source (output valid, output raw_levels, input ready);
  modport sink   (input valid, input raw_levels, output ready);
endinterface

interface mccd_out_if;
  logic              valid;
  logic              ready;
  mccd_pkg::field_t  debounced_levels;
  mccd_pkg::field_t  press_events;

  modport source (output valid, output debounced_levels, output press_events, input ready);
  modport sink   (input valid, input debounced_levels, input press_events, output ready);
endinterface

// File: rtl/core/mccd_lane.sv
// mccd_lane: one channel's integrating counter, debounced level and press toggle
// depends on mccd_pkg
`timescale 1ns / 1ps

module mccd_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic                raw_i,
  input  mccd_pkg::count_t    threshold_i,
  output mccd_pkg::lane_out_t lane_o
);
  import mccd_pkg::*;

  logic   stable_q, stable_d;
  logic   toggle_q, toggle_d;
  count_t cnt_q, cnt_d;
  count_t cnt_step;
  logic   hit;

  // count up on disagreement (saturating), down on agreement (floor at zero)
  always_comb begin
    if (raw_i == stable_q) begin
      cnt_step = (cnt_q != '0) ? cnt_q - count_t'(1) : '0;
    end else begin
      cnt_step = (cnt_q != CNT_MAX) ? cnt_q + count_t'(1) : CNT_MAX;
    end
  end

  // threshold reached: take the raw level and flip the toggle
  assign hit      = (cnt_step >= threshold_i);
  assign cnt_d    = hit ? '0 : cnt_step;
  assign stable_d = hit ? raw_i : stable_q;
  assign toggle_d = hit ? ~toggle_q : toggle_q;

  assign lane_o.level = stable_d;
  assign lane_o.press = hit & ~toggle_q;

  // lane state advances only on an accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= 1'b1;
      toggle_q <= 1'b0;
      cnt_q    <= '0;
    end else if (accept_i) begin
      stable_q <= stable_d;
      toggle_q <= toggle_d;
      cnt_q    <= cnt_d;
    end
  end

  // counter clears after an accepted change
  a_clear_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && hit |=> cnt_q == '0)
    else $error("counter not cleared after accepted change");

  // a press leaves the toggle set
  a_press_sets_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && lane_o.press |=> toggle_q)
    else $error("toggle not set after press");

  // state holds while no request is taken
  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |=> $stable(cnt_q) && $stable(stable_q) && $stable(toggle_q))
    else $error("lane state changed without a request");

  // zero threshold accepts every sample
  a_zero_threshold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && threshold_i == '0 |-> hit)
    else $error("zero threshold did not accept");

endmodule

// File: rtl/core/mccd_merge.sv
// mccd_merge: gathers lane results into the output words and holds them in
// the output register; depends on mccd_pkg and mccd_out_if
`timescale 1ns / 1ps

module mccd_merge #(
  parameter int unsigned CHANNELS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  mccd_pkg::lane_out_t lanes_i [CHANNELS],
  output logic                ready_o,
  mccd_out_if.source          out_rsp
);
  import mccd_pkg::*;

  logic   valid_q;
  field_t levels_d, levels_q;
  field_t events_d, events_q;

  // pack lane bits; bits of missing channels stay zero
  for (genvar b = 0; b < FIELD_W; b++) begin : g_bit
    if (b < CHANNELS) begin : g_used
      assign levels_d[b] = lanes_i[b].level;
      assign events_d[b] = lanes_i[b].press;
    end else begin : g_unused
      assign levels_d[b] = 1'b0;
      assign events_d[b] = 1'b0;
    end
  end

  // a new request may enter whenever the held result leaves or none is held
  assign ready_o = !valid_q || out_rsp.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= accept_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      levels_q <= levels_d;
      events_q <= events_d;
    end
  end

  assign out_rsp.valid            = valid_q;
  assign out_rsp.debounced_levels = levels_q;
  assign out_rsp.press_events     = events_q;

endmodule

// File: rtl/core/multi_channel_counter_debouncer.sv
// channel   dir  payload                                  width
// in_req    in   raw_levels                               16
// out_rsp   out  debounced_levels, press_events           16, 16
// cfg       in   cfg_we_i / cfg_wdata_i (threshold)       8
//
// one request per cycle unless the output stalls; its result appears in the
// output register in the cycle after it is taken, all lanes updating in parallel
// in that same cycle. input ready is high whenever the output register is empty
// or being drained. reset sets every debounced level high, counters and toggles
// to zero and the threshold to 10; no clearing pass is needed.
// a stalled output holds its result and blocks new requests until taken.
//
// depends on mccd_pkg, mccd_stream_if, mccd_lane, mccd_merge
`timescale 1ns / 1ps

module multi_channel_counter_debouncer #(
  parameter int unsigned CHANNELS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  mccd_in_if.sink          in_req,
  mccd_out_if.source       out_rsp,
  input  logic             cfg_we_i,
  input  mccd_pkg::count_t cfg_wdata_i
);
  import mccd_pkg::*;

  count_t    threshold_q;
  logic      accept;
  logic      ready;
  lane_out_t lanes [CHANNELS];

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RESET;
    end else if (cfg_we_i) begin
      threshold_q <= cfg_wdata_i;
    end
  end

  assign in_req.ready = ready;
  assign accept       = in_req.valid && ready;

  // one lane per channel; channels past the input word see a low level
  for (genvar k = 0; k < CHANNELS; k++) begin : g_lane
    logic raw_bit;
    if (k < FIELD_W) begin : g_in
      assign raw_bit = in_req.raw_levels[k];
    end else begin : g_pad
      assign raw_bit = 1'b0;
    end

    mccd_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .accept_i    (accept),
      .raw_i       (raw_bit),
      .threshold_i (threshold_q),
      .lane_o      (lanes[k])
    );
  end

  // merge lanes into the result words
  mccd_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .lanes_i  (lanes),
    .ready_o  (ready),
    .out_rsp  (out_rsp)
  );

endmodule
